// ===== sv/bdcw_pkg.sv =====
`timescale 1ns / 1ps

package bdcw_pkg;

   localparam int HDR_LEN = 54;
   localparam logic [12:0] MAX_DIM = 13'd4096;

   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_PIX_FMT    = 2'd2;

   localparam logic [1:0] FMT_RGB565 = 2'd0;
   localparam logic [1:0] FMT_BGRX   = 2'd1;

   localparam logic [5:0] IDX_PIX_B    = 6'd54;
   localparam logic [5:0] IDX_PIX_R    = 6'd56;
   localparam logic [5:0] IDX_PIX_END  = 6'd57;

   typedef struct packed {
      logic        hdr;
      logic        kept;
      logic        empty;
      logic        row_end;
      logic        frame_end;
      logic [1:0]  pad;
      logic [11:0] new_w;
      logic [11:0] new_h;
      logic [7:0]  b;
      logic [7:0]  g;
      logic [7:0]  r;
   } job_type;

   function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [31:0] fsize,
                                           input logic [31:0] width, input logic [31:0] height);
      logic [7:0] v;
      v = 8'd0;
      case (idx)
         6'd0:    v = 8'h42;
         6'd1:    v = 8'h4D;
         6'd2:    v = fsize[7:0];
         6'd3:    v = fsize[15:8];
         6'd4:    v = fsize[23:16];
         6'd5:    v = fsize[31:24];
         6'd10:   v = 8'd54;
         6'd14:   v = 8'd40;
         6'd18:   v = width[7:0];
         6'd19:   v = width[15:8];
         6'd20:   v = width[23:16];
         6'd21:   v = width[31:24];
         6'd22:   v = height[7:0];
         6'd23:   v = height[15:8];
         6'd24:   v = height[23:16];
         6'd25:   v = height[31:24];
         6'd26:   v = 8'd1;
         6'd28:   v = 8'd24;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/bdcw_emit.sv =====
`timescale 1ns / 1ps

module bdcw_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_load,
   input  bdcw_pkg::job_type job,
   output logic             job_free,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte
   output logic             rsp_tlast,  // run_last
   output logic             rsp_tuser   // file_last
);
   import bdcw_pkg::*;

   job_type     job_ff;
   logic        job_valid_ff;
   logic [5:0]  idx_ff;
   logic        rsp_valid_ff;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic        flast_ff;

   logic        advance;
   logic [5:0]  end_idx;
   logic        last;
   logic        flast;
   logic [13:0] row_bytes;
   logic [31:0] fsize;
   logic [31:0] width32;
   logic [31:0] neg_h32;
   logic [7:0]  byte_in;

   assign advance = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign end_idx = job_ff.kept ?
                    (IDX_PIX_END + (job_ff.row_end ? {4'd0, job_ff.pad} : 6'd0)) : IDX_PIX_B;
   assign last    = (idx_ff == end_idx - 6'd1);
   assign flast   = last && (job_ff.kept ? job_ff.frame_end : job_ff.empty);
   assign job_free = !job_valid_ff || (advance && last);

   assign row_bytes = {1'b0, job_ff.new_w, 1'b0} + {2'b00, job_ff.new_w}
                      + {12'd0, job_ff.pad};
   assign fsize     = 32'(HDR_LEN) + ({18'd0, row_bytes} * {20'd0, job_ff.new_h});
   assign width32   = {20'd0, job_ff.new_w};
   assign neg_h32   = 32'd0 - {20'd0, job_ff.new_h};

   always_comb begin
      if (idx_ff < IDX_PIX_B) begin
         byte_in = hdr_byte(idx_ff, fsize, width32, neg_h32);
      end else if (idx_ff == IDX_PIX_B) begin
         byte_in = job_ff.b;
      end else if (idx_ff < IDX_PIX_R) begin
         byte_in = job_ff.g;
      end else if (idx_ff == IDX_PIX_R) begin
         byte_in = job_ff.r;
      end else begin
         byte_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 6'd0;
      end else if (job_load && job_free) begin
         job_valid_ff <= 1'b1;
         idx_ff       <= job.hdr ? 6'd0 : IDX_PIX_B;
      end else if (advance && last) begin
         job_valid_ff <= 1'b0;
      end else if (advance) begin
         idx_ff <= idx_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load && job_free) begin
         job_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff  <= byte_in;
         last_ff  <= last;
         flast_ff <= flast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = flast_ff;

endmodule

// ===== sv/bmp_downscale_capture_writer_core.sv =====
`timescale 1ns / 1ps
// A taken pixel is stored in the job register; its bytes then pass through the output register.
// Throughput: one byte per cycle while rsp_tready is high; pixels that yield nothing are taken
// one per cycle while the emitter is free. A kept pixel's three to six bytes, or up to 60 with
// the header, hold the input. The rate is set by the single byte-wide output register.
// Reset (synchronous) restores the register defaults and restarts the frame with a new header.

module bmp_downscale_capture_writer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // file_last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bdcw_pkg::*;

   logic [12:0] src_width_ff;
   logic [12:0] src_height_ff;
   logic [1:0]  pixel_format_ff;
   logic [11:0] column_count_ff;
   logic [11:0] row_count_ff;
   logic        header_done_ff;

   logic [11:0] column_count_in;
   logic [11:0] row_count_in;
   logic        header_done_in;

   logic        csr_write;
   logic [12:0] w_cl;
   logic [12:0] h_cl;
   logic [11:0] new_w;
   logic [11:0] new_h;
   logic        empty;
   logic        kept;
   logic        col_wrap;
   logic        row_wrap;
   logic        accept;
   logic        job_load;
   logic        job_free;
   job_type     job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= 13'd800;
         src_height_ff   <= 13'd480;
         pixel_format_ff <= FMT_BGRX;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_SRC_WIDTH:  src_width_ff    <= csr_pwdata[12:0];
            REG_SRC_HEIGHT: src_height_ff   <= csr_pwdata[12:0];
            REG_PIX_FMT:    pixel_format_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SRC_WIDTH:  csr_prdata = {19'd0, src_width_ff};
         REG_SRC_HEIGHT: csr_prdata = {19'd0, src_height_ff};
         REG_PIX_FMT:    csr_prdata = {30'd0, pixel_format_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign w_cl = (src_width_ff == 13'd0) ? 13'd1 :
                 ((src_width_ff > MAX_DIM) ? MAX_DIM : src_width_ff);
   assign h_cl = (src_height_ff == 13'd0) ? 13'd1 :
                 ((src_height_ff > MAX_DIM) ? MAX_DIM : src_height_ff);
   assign new_w = w_cl[12:1];
   assign new_h = h_cl[12:1];
   assign empty = (new_w == 12'd0) || (new_h == 12'd0);

   assign kept = !empty && !column_count_ff[0] && !row_count_ff[0]
                 && ({1'b0, column_count_ff[11:1]} < new_w)
                 && ({1'b0, row_count_ff[11:1]} < new_h);

   always_comb begin
      job           = '0;
      job.hdr       = !header_done_ff;
      job.kept      = kept;
      job.empty     = empty;
      job.row_end   = ({1'b0, column_count_ff[11:1]} == new_w - 12'd1);
      job.frame_end = job.row_end && ({1'b0, row_count_ff[11:1]} == new_h - 12'd1);
      job.pad       = new_w[1:0];
      job.new_w     = new_w;
      job.new_h     = new_h;
      case (pixel_format_ff)
         FMT_BGRX: begin
            job.b = req_tdata[7:0];
            job.g = req_tdata[15:8];
            job.r = req_tdata[23:16];
         end
         FMT_RGB565: begin
            job.b = {req_tdata[4:0], 3'd0};
            job.g = {req_tdata[10:5], 2'd0};
            job.r = {req_tdata[15:11], 3'd0};
         end
         default: begin
            job.b = 8'd0;
            job.g = 8'd0;
            job.r = 8'd0;
         end
      endcase
   end

   assign req_tready = job_free;
   assign accept     = req_tvalid && req_tready;
   assign job_load   = accept && (!header_done_ff || kept);

   assign col_wrap = ({1'b0, column_count_ff} + 13'd1) >= w_cl;
   assign row_wrap = ({1'b0, row_count_ff} + 13'd1) >= h_cl;

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      header_done_in  = header_done_ff;
      if (accept) begin
         header_done_in = 1'b1;
         if (col_wrap) begin
            column_count_in = 12'd0;
            if (row_wrap) begin
               row_count_in   = 12'd0;
               header_done_in = 1'b0;
            end else begin
               row_count_in = row_count_ff + 12'd1;
            end
         end else begin
            column_count_in = column_count_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 12'd0;
         row_count_ff    <= 12'd0;
         header_done_ff  <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         header_done_ff  <= header_done_in;
      end
   end

   bdcw_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_load   (job_load),
      .job        (job),
      .job_free   (job_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== bench/bmp_downscale_capture_writer_core_test.sv =====
`timescale 1ns / 1ps

module bmp_downscale_capture_writer_core_test;

   import bdcw_pkg::*;

   localparam logic [1:0] FMT_NONE  = 2'd2;
   localparam logic [1:0] FMT_SPARE = 2'd3;
   localparam logic [1:0] NO_REG    = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic {ROW_PIX, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   idx;
      logic [31:0]  value;
      logic         typed;
      logic [23:0]  rgb;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       flast;
   } file_byte_type;

   localparam int DIR_LEN = 32;

   // Typed colours are {R,G,B}; untyped rows are left to the encoder below.
   localparam dir_row_type DIR_ROWS [DIR_LEN] = '{
      '{ROW_PIX, NO_REG, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF},
      '{ROW_PIX, NO_REG, 32'hA5A5_A5A5, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_0000, 1'b1, 24'h00_0000},
      '{ROW_CSR, REG_PIX_FMT, 32'(FMT_RGB565), 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h5A5A_5A5A, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'hFFFF_FFFF, 1'b1, 24'hF8_FCF8},
      '{ROW_PIX, NO_REG, 32'h1234_5678, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_F800, 1'b1, 24'hF8_0000},
      '{ROW_PIX, NO_REG, 32'h8765_4321, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_07E0, 1'b1, 24'h00_FC00},
      '{ROW_PIX, NO_REG, 32'hFFFF_0000, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_001F, 1'b1, 24'h00_00F8},
      '{ROW_CSR, REG_PIX_FMT, 32'(FMT_NONE), 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'hFFFF_FFFF, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'hFFFF_FFFF, 1'b1, 24'h00_0000},
      '{ROW_CSR, REG_PIX_FMT, 32'(FMT_SPARE), 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_0000, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'hFFFF_FFFF, 1'b1, 24'h00_0000},
      '{ROW_CSR, REG_SRC_WIDTH, 32'd0, 1'b0, 24'h00_0000},
      '{ROW_CSR, REG_SRC_HEIGHT, 32'd0, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_0000, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_0000, 1'b0, 24'h00_0000},
      '{ROW_CSR, REG_SRC_WIDTH, 32'd8191, 1'b0, 24'h00_0000},
      '{ROW_CSR, REG_SRC_HEIGHT, 32'd4096, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'hCAFE_F00D, 1'b1, 24'h00_0000},
      '{ROW_CSR, REG_PIX_FMT, 32'(FMT_BGRX), 1'b0, 24'h00_0000},
      '{ROW_CSR, REG_SRC_WIDTH, 32'd2, 1'b0, 24'h00_0000},
      '{ROW_CSR, REG_SRC_HEIGHT, 32'd2, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_0000, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_0000, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0000_0000, 1'b0, 24'h00_0000},
      '{ROW_PIX, NO_REG, 32'h0011_2233, 1'b1, 24'h11_2233}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic        pix_typed = 1'b0;
   logic [23:0] pix_typed_rgb = 24'd0;

   logic [12:0] cfg_w = 13'd800;
   logic [12:0] cfg_h = 13'd480;
   logic [1:0]  cfg_fmt = FMT_BGRX;
   logic [11:0] col_pos = 12'd0;
   logic [11:0] row_pos = 12'd0;
   logic        hdr_sent = 1'b0;

   file_byte_type file_bytes_due [$];
   file_byte_type got_due;

   bit idle_on = 1'b1;
   int stall_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int pixels_sent = 0;
   int bytes_seen = 0;
   int files_closed = 0;
   int reg_writes = 0;

   always #1 clock = ~clock;

   bmp_downscale_capture_writer_core u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic int fit_dim(input logic [12:0] v);
      if (v == 13'd0) return 1;
      if (v > MAX_DIM) return int'(MAX_DIM);
      return int'(v);
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s expected %0h got %0h", what, want, got);
      end
   endtask

   // Works out the file bytes that one accepted pixel adds to the stream.
   task automatic encode_pixel(input logic [31:0] pix, input logic typed,
                               input logic [23:0] typed_rgb);
      int w, h, nw, nh, pad;
      logic [31:0] fsize, negh;
      logic [7:0] hdr [HDR_LEN];
      logic [7:0] b, g, r;
      logic empty, row_end, frame_end;
      file_byte_type run [$];
      w = fit_dim(cfg_w);
      h = fit_dim(cfg_h);
      nw = w / 2;
      nh = h / 2;
      pad = (4 - (nw * 3) % 4) % 4;
      empty = (nw == 0) || (nh == 0);
      if (!hdr_sent) begin
         fsize = HDR_LEN + (nw * 3 + pad) * nh;
         negh = -nh;
         foreach (hdr[i]) hdr[i] = 8'd0;
         hdr[0] = 8'h42;
         hdr[1] = 8'h4D;
         {hdr[5], hdr[4], hdr[3], hdr[2]} = fsize;
         hdr[10] = 8'(HDR_LEN);
         hdr[14] = 8'd40;
         {hdr[21], hdr[20], hdr[19], hdr[18]} = 32'(nw);
         {hdr[25], hdr[24], hdr[23], hdr[22]} = negh;
         hdr[26] = 8'd1;
         hdr[28] = 8'd24;
         for (int i = 0; i < HDR_LEN; i++) begin
            run.push_back('{hdr[i], 1'b0, empty && (i == HDR_LEN - 1)});
         end
         hdr_sent = 1'b1;
      end
      if (!empty && !col_pos[0] && !row_pos[0] && int'(col_pos >> 1) < nw &&
          int'(row_pos >> 1) < nh) begin
         row_end = int'(col_pos >> 1) == nw - 1;
         frame_end = row_end && int'(row_pos >> 1) == nh - 1;
         case (cfg_fmt)
            FMT_BGRX: begin
               {r, g, b} = pix[23:0];
            end
            FMT_RGB565: begin
               b = {pix[4:0], 3'b000};
               g = {pix[10:5], 2'b00};
               r = {pix[15:11], 3'b000};
            end
            default: begin
               {r, g, b} = 24'd0;
            end
         endcase
         if (typed) {r, g, b} = typed_rgb;
         run.push_back('{b, 1'b0, 1'b0});
         run.push_back('{g, 1'b0, 1'b0});
         run.push_back('{r, 1'b0, frame_end && (pad == 0)});
         if (row_end) begin
            for (int p = 0; p < pad; p++) begin
               run.push_back('{8'd0, 1'b0, frame_end && (p == pad - 1)});
            end
         end
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) file_bytes_due.push_back(run[i]);
      if (int'(col_pos) + 1 >= w) begin
         col_pos = 12'd0;
         if (int'(row_pos) + 1 >= h) begin
            row_pos = 12'd0;
            hdr_sent = 1'b0;
         end else begin
            row_pos = row_pos + 12'd1;
         end
      end else begin
         col_pos = col_pos + 12'd1;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) encode_pixel(req_tdata, pix_typed, pix_typed_rgb);
         if (rsp_tvalid && rsp_tready) begin
            if (file_bytes_due.size() == 0) begin
               note_mismatch("word with nothing expected", 32'd0, 32'(rsp_tdata));
            end else begin
               got_due = file_bytes_due.pop_front();
               if (rsp_tdata !== got_due.data) begin
                  note_mismatch("byte", 32'(got_due.data), 32'(rsp_tdata));
               end
               if (rsp_tlast !== got_due.last) begin
                  note_mismatch("tlast", 32'(got_due.last), 32'(rsp_tlast));
               end
               if (rsp_tuser !== got_due.flast) begin
                  note_mismatch("tuser", 32'(got_due.flast), 32'(rsp_tuser));
               end
               bytes_seen++;
               if (got_due.flast) files_closed++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_pixel(input logic [31:0] pix, input logic typed,
                             input logic [23:0] rgb);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      pix_typed <= typed;
      pix_typed_rgb <= rgb;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // Writes a register once the stream has drained, then reads it back.
   task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
      logic [31:0] want;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (file_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {19'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SRC_WIDTH:  cfg_w = val;
         REG_SRC_HEIGHT: cfg_h = val;
         default:        cfg_fmt = val[1:0];
      endcase
      want = (idx == REG_PIX_FMT) ? {30'd0, val[1:0]} : {19'd0, val};
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) note_mismatch("register read", want, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      reg_writes++;
   endtask

   task automatic run_phase(input bit wide_dims);
      logic [12:0] w, h;
      int n, area;
      w = 13'($urandom_range(2, 9));
      h = 13'($urandom_range(2, 5));
      if (wide_dims) begin
         case ($urandom_range(0, 7))
            0: begin
               case ($urandom_range(0, 3))
                  0: w = 13'd0;
                  1: w = 13'd1;
                  2: w = MAX_DIM;
                  default: w = 13'($urandom_range(4097, 8191));
               endcase
            end
            1: begin
               case ($urandom_range(0, 3))
                  0: h = 13'd0;
                  1: h = 13'd1;
                  2: h = MAX_DIM;
                  default: h = 13'($urandom_range(4097, 8191));
               endcase
            end
            default: ;
         endcase
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_WIDTH, w);
      if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_HEIGHT, h);
      if ($urandom_range(0, 3) != 0) write_reg(REG_PIX_FMT, 13'($urandom_range(0, 3)));
      area = fit_dim(cfg_w) * fit_dim(cfg_h);
      if (area > 64) n = $urandom_range(1, 6);
      else n = area * $urandom_range(1, 2) + $urandom_range(0, 3);
      repeat (n) send_pixel($urandom, 1'b0, 24'd0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].kind == ROW_CSR) begin
            write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value[12:0]);
         end else begin
            send_pixel(DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].rgb);
         end
      end
      while (pixels_sent < 230) run_phase(1'b1);
      // The closing stretch runs both sides flat out.
      idle_on = 1'b0;
      while (pixels_sent < 270) run_phase(1'b0);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (file_bytes_due.size() != 0);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d pixels and %0d stream bytes, %0d files closed", pixels_sent,
               bytes_seen, files_closed);
      $display("%0d register writes across sizes, formats and mid-frame changes", reg_writes);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
